### hdl/elastic_sketch_update_top_defines.svh
// assertion macros for the elastic sketch update block
`ifndef ELASTIC_SKETCH_UPDATE_TOP_DEFINES_SVH
`define ELASTIC_SKETCH_UPDATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// check with reset masking
`define ES_ASSERT_ON(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");
// check that also holds through reset
`define ES_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define ES_ASSERT_ON(lbl, clk, rstn, prop)
`define ES_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### hdl/es_pkg.sv
// shared types, codes and constants of the elastic sketch update block
package es_pkg;

    localparam int unsigned BUCKET_COUNT_DEF = 1024;
    localparam int unsigned LIGHT_ROWS_DEF   = 3;
    localparam int unsigned LIGHT_COLS_DEF   = 4096;

    localparam logic [7:0]  VOTE_RATIO_RST = 8'd8;
    localparam logic [31:0] VOTE_MAX       = 32'hFFFF_FFFF;
    localparam logic [31:0] HEAVY_SEED     = 32'h0000_005A;
    localparam logic [63:0] GOLDEN         = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] FIN_MUL1       = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] FIN_MUL2       = 64'h94D0_49BB_1331_11EB;

    localparam logic [1:0] ACT_UPDATE   = 2'd0;
    localparam logic [1:0] ACT_RD_HEAVY = 2'd1;
    localparam logic [1:0] ACT_RD_LIGHT = 2'd2;

    localparam logic [2:0] OUT_INSERT  = 3'd0;
    localparam logic [2:0] OUT_HIT     = 3'd1;
    localparam logic [2:0] OUT_VOTE    = 3'd2;
    localparam logic [2:0] OUT_EVICT   = 3'd3;
    localparam logic [2:0] OUT_READ    = 3'd4;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] pos;
        logic [31:0] neg;
        logic        flag;
    } t_bucket;

    typedef struct packed {
        logic load_in;
        logic hash_start;
        logic hash_heavy;
        logic heavy_rd;
        logic rd_from_hash;
        logic mul;
        logic decide;
        logic light_rd;
        logic rd_loop;
        logic light_wr;
        logic row_inc;
        logic clr_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       hash_done;
        logic       need_light;
        logic       last_row;
        logic       clr_last;
        logic       out_free;
    } t_dp_sts;

    // seed premix, only evaluated on constants
    function automatic logic [63:0] seed_mix(input logic [31:0] seed);
        return (64'(seed) + 64'd1) * GOLDEN;
    endfunction

endpackage

### hdl/es_hash.sv
// multicycle key hash with splitmix finalizer and reciprocal modulo
module es_hash import es_pkg::*; #(
    parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF,
    parameter int unsigned LIGHT_COLS   = LIGHT_COLS_DEF,
    localparam int unsigned DMAX = (BUCKET_COUNT > LIGHT_COLS) ? BUCKET_COUNT : LIGHT_COLS,
    localparam int unsigned RW   = $clog2(DMAX) + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_heavy,
    input  logic [63:0]   i_key,
    input  logic [63:0]   i_mix,
    output logic          o_done,
    output logic [RW-1:0] o_rem
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_M1   = 3'd1;
    localparam logic [2:0] PH_M2   = 3'd2;
    localparam logic [2:0] PH_Q    = 3'd3;
    localparam logic [2:0] PH_R    = 3'd4;
    localparam logic [2:0] PH_C    = 3'd5;

    // floor(2^32 / divisor): the quotient estimate is at most one low
    localparam logic [31:0] RECIP_H = 32'(64'h1_0000_0000 / 64'(BUCKET_COUNT));
    localparam logic [31:0] RECIP_L = 32'(64'h1_0000_0000 / 64'(LIGHT_COLS));

    logic [2:0]    r_ph;
    logic [1:0]    r_k;
    logic [63:0]   r_x;
    logic [63:0]   r_acc;
    logic [31:0]   r_q;
    logic [31:0]   r_r;
    logic [RW-1:0] r_rem;
    logic          r_heavy;
    logic          r_done;

    logic [63:0]   x0;
    logic [63:0]   mul_const;
    logic [31:0]   op_a;
    logic [31:0]   op_b;
    logic [63:0]   prod;
    logic [63:0]   acc_sum;
    logic [31:0]   hv;
    logic [31:0]   dvs;
    logic [31:0]   recip;
    logic [63:0]   qprod;
    logic [31:0]   qd;
    logic [31:0]   fix1;
    logic [31:0]   fix2;

    assign x0        = i_key ^ i_mix;
    assign mul_const = (r_ph == PH_M1) ? FIN_MUL1 : FIN_MUL2;
    assign op_a      = (r_k == 2'd2) ? r_x[63:32] : r_x[31:0];
    assign op_b      = (r_k == 2'd1) ? mul_const[63:32] : mul_const[31:0];
    assign prod      = op_a * op_b;
    // low 64 bits of a 64x64 product from three partial products
    assign acc_sum   = (r_k == 2'd0) ? prod : (r_acc + {prod[31:0], 32'd0});

    assign hv    = r_x[63:32];
    assign dvs   = r_heavy ? 32'(BUCKET_COUNT) : 32'(LIGHT_COLS);
    assign recip = r_heavy ? RECIP_H : RECIP_L;
    assign qprod = 64'(hv) * 64'(recip);
    assign qd    = r_q * dvs;
    assign fix1  = (r_r >= dvs) ? (r_r - dvs) : r_r;
    assign fix2  = (fix1 >= dvs) ? (fix1 - dvs) : fix1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_k    <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_ph == PH_C);
            case (r_ph)
                PH_IDLE: begin
                    if (i_start) begin
                        r_x     <= x0 ^ (x0 >> 30);
                        r_k     <= 2'd0;
                        r_heavy <= i_heavy;
                        r_ph    <= PH_M1;
                    end
                end
                PH_M1, PH_M2: begin
                    r_acc <= acc_sum;
                    if (r_k == 2'd2) begin
                        r_k <= 2'd0;
                        if (r_ph == PH_M1) begin
                            r_x  <= acc_sum ^ (acc_sum >> 27);
                            r_ph <= PH_M2;
                        end else begin
                            r_x  <= acc_sum ^ (acc_sum >> 31);
                            r_ph <= PH_Q;
                        end
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                PH_Q: begin
                    r_q  <= qprod[63:32];
                    r_ph <= PH_R;
                end
                PH_R: begin
                    r_r  <= hv - qd;
                    r_ph <= PH_C;
                end
                PH_C: begin
                    r_rem <= fix2[RW-1:0];
                    r_ph  <= PH_IDLE;
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### hdl/es_dp.sv
// datapath: heavy and light memories, hash unit, vote logic, result register
module es_dp import es_pkg::*; #(
    parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF,
    parameter int unsigned LIGHT_ROWS   = LIGHT_ROWS_DEF,
    parameter int unsigned LIGHT_COLS   = LIGHT_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_flow_key,
    input  logic [13:0] i_read_index,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [2:0]  o_outcome,
    output logic [63:0] o_result_key,
    output logic [31:0] o_result_pos_votes,
    output logic [31:0] o_result_neg_votes,
    output logic        o_result_flag,
    output logic [31:0] o_light_value
);

    localparam int unsigned HW    = $clog2(BUCKET_COUNT);
    localparam int unsigned LSZ   = LIGHT_ROWS * LIGHT_COLS;
    localparam int unsigned LAW   = $clog2(LSZ);
    localparam int unsigned RWID  = (LIGHT_ROWS > 1) ? $clog2(LIGHT_ROWS) : 1;
    localparam int unsigned MAXSZ = (BUCKET_COUNT > LSZ) ? BUCKET_COUNT : LSZ;
    localparam int unsigned CW    = $clog2(MAXSZ + 1);
    localparam int unsigned DMAX  = (BUCKET_COUNT > LIGHT_COLS) ? BUCKET_COUNT : LIGHT_COLS;
    localparam int unsigned RW    = $clog2(DMAX) + 1;
    localparam logic [63:0] HEAVY_MIX = seed_mix(HEAVY_SEED);

    t_bucket       r_heavy_mem [BUCKET_COUNT];
    logic [31:0]   r_light_mem [LSZ];

    logic [1:0]    r_action;
    logic [63:0]   r_key;
    logic [13:0]   r_idx;
    logic [7:0]    r_vote_ratio;
    logic [HW-1:0] r_hidx;
    t_bucket       r_hq;
    logic [31:0]   r_lq;
    logic [31:0]   r_negn;
    logic [39:0]   r_prod;
    logic [63:0]   r_lkey;
    logic [31:0]   r_lamt;
    logic [RWID-1:0] r_row;
    logic [LAW-1:0]  r_laddr;
    logic [CW-1:0]   r_clr;
    logic [2:0]    r_res_outcome;
    logic [63:0]   r_res_key;
    logic [31:0]   r_res_pos;
    logic          r_out_valid;
    logic [2:0]    r_o_outcome;
    logic [63:0]   r_o_key;
    logic [31:0]   r_o_pos;
    logic [31:0]   r_o_neg;
    logic          r_o_flag;
    logic [31:0]   r_o_light;

    logic [63:0]   w_mix_tab [LIGHT_ROWS];
    logic [63:0]   hash_mix;
    logic [63:0]   hash_key;
    logic          hash_done;
    logic [RW-1:0] hash_rem;
    logic [31:0]   idx32;
    logic          heavy_in_range;
    logic          light_in_range;
    logic [HW-1:0] heavy_addr;
    logic [31:0]   loop_addr32;
    logic [LAW-1:0] light_addr;
    logic          is_empty;
    logic          is_match;
    logic          is_evict;
    logic [31:0]   pos_inc;
    logic [31:0]   neg_inc;
    t_bucket       wb;

    genvar g;
    generate
        for (g = 0; g < LIGHT_ROWS; g++) begin : g_mix
            localparam logic [63:0] ROW_MIX = seed_mix(32'(g));
            assign w_mix_tab[g] = ROW_MIX;
        end
    endgenerate

    assign hash_mix = i_cmd.hash_heavy ? HEAVY_MIX : w_mix_tab[r_row];
    assign hash_key = i_cmd.hash_heavy ? r_key : r_lkey;

    es_hash #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .LIGHT_COLS   (LIGHT_COLS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.hash_start),
        .i_heavy (i_cmd.hash_heavy),
        .i_key   (hash_key),
        .i_mix   (hash_mix),
        .o_done  (hash_done),
        .o_rem   (hash_rem)
    );

    assign idx32          = 32'(r_idx);
    assign heavy_in_range = idx32 < 32'(BUCKET_COUNT);
    assign light_in_range = idx32 < 32'(LSZ);
    assign heavy_addr     = i_cmd.rd_from_hash ? hash_rem[HW-1:0] : idx32[HW-1:0];
    assign loop_addr32    = 32'(r_row) * 32'(LIGHT_COLS) + 32'(hash_rem);
    assign light_addr     = i_cmd.rd_loop ? loop_addr32[LAW-1:0] : idx32[LAW-1:0];

    // vote decision on the fetched bucket
    assign is_empty = (r_hq.key == 64'd0);
    assign is_match = (r_hq.key == r_key);
    assign is_evict = (r_hq.pos != 32'd0) && ({8'd0, r_negn} >= r_prod);
    assign pos_inc  = (r_hq.pos == VOTE_MAX) ? r_hq.pos : (r_hq.pos + 32'd1);
    assign neg_inc  = (r_hq.neg == VOTE_MAX) ? r_hq.neg : (r_hq.neg + 32'd1);

    always_comb begin
        wb = r_hq;
        if (is_empty) begin
            wb = '{key: r_key, pos: 32'd1, neg: 32'd0, flag: 1'b0};
        end else if (is_match) begin
            wb.pos = pos_inc;
        end else if (is_evict) begin
            wb = '{key: r_key, pos: 32'd1, neg: 32'd0, flag: 1'b1};
        end else begin
            wb.neg = r_negn;
        end
    end

    // heavy memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            if (r_clr < CW'(BUCKET_COUNT)) begin
                r_heavy_mem[r_clr[HW-1:0]] <= '0;
            end
        end else if (i_cmd.decide) begin
            r_heavy_mem[r_hidx] <= wb;
        end
        if (i_cmd.heavy_rd) begin
            r_hq <= r_heavy_mem[heavy_addr];
        end
    end

    // light memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            if (r_clr < CW'(LSZ)) begin
                r_light_mem[r_clr[LAW-1:0]] <= 32'd0;
            end
        end else if (i_cmd.light_wr) begin
            r_light_mem[r_laddr] <= r_lq + r_lamt;
        end
        if (i_cmd.light_rd) begin
            r_lq <= r_light_mem[light_addr];
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_action;
            r_key    <= i_flow_key;
            r_idx    <= i_read_index;
        end
        if (i_cmd.heavy_rd) begin
            r_hidx <= heavy_addr;
        end
        if (i_cmd.light_rd) begin
            r_laddr <= light_addr;
        end
        if (i_cmd.mul) begin
            r_negn <= neg_inc;
            r_prod <= r_vote_ratio * r_hq.pos;
        end
        if (i_cmd.decide) begin
            if (is_empty) begin
                r_res_outcome <= OUT_INSERT;
                r_res_key     <= 64'd0;
                r_res_pos     <= 32'd0;
                r_lkey        <= r_key;
                r_lamt        <= 32'd1;
            end else if (is_match) begin
                r_res_outcome <= OUT_HIT;
                r_res_key     <= 64'd0;
                r_res_pos     <= 32'd0;
                r_lkey        <= r_key;
                r_lamt        <= 32'd1;
            end else if (is_evict) begin
                r_res_outcome <= OUT_EVICT;
                r_res_key     <= r_hq.key;
                r_res_pos     <= r_hq.pos;
                r_lkey        <= r_hq.key;
                r_lamt        <= r_hq.pos;
            end else begin
                r_res_outcome <= OUT_VOTE;
                r_res_key     <= 64'd0;
                r_res_pos     <= 32'd0;
                r_lkey        <= r_key;
                r_lamt        <= 32'd1;
            end
        end
        if (i_cmd.out_load) begin
            case (r_action)
                ACT_RD_HEAVY: begin
                    r_o_outcome <= OUT_READ;
                    r_o_key     <= heavy_in_range ? r_hq.key : 64'd0;
                    r_o_pos     <= heavy_in_range ? r_hq.pos : 32'd0;
                    r_o_neg     <= heavy_in_range ? r_hq.neg : 32'd0;
                    r_o_flag    <= heavy_in_range ? r_hq.flag : 1'b0;
                    r_o_light   <= 32'd0;
                end
                ACT_RD_LIGHT: begin
                    r_o_outcome <= OUT_READ;
                    r_o_key     <= 64'd0;
                    r_o_pos     <= 32'd0;
                    r_o_neg     <= 32'd0;
                    r_o_flag    <= 1'b0;
                    r_o_light   <= light_in_range ? r_lq : 32'd0;
                end
                default: begin
                    r_o_outcome <= r_res_outcome;
                    r_o_key     <= r_res_key;
                    r_o_pos     <= r_res_pos;
                    r_o_neg     <= 32'd0;
                    r_o_flag    <= 1'b0;
                    r_o_light   <= 32'd0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vote_ratio <= VOTE_RATIO_RST;
            r_clr        <= '0;
            r_row        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vote_ratio <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + CW'(1);
            end
            if (i_cmd.decide) begin
                r_row <= '0;
            end else if (i_cmd.row_inc) begin
                r_row <= r_row + RWID'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.action     = r_action;
    assign o_sts.hash_done  = hash_done;
    assign o_sts.need_light = !is_empty && !is_match;
    assign o_sts.last_row   = (r_row == RWID'(LIGHT_ROWS - 1));
    assign o_sts.clr_last   = (r_clr == CW'(MAXSZ - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_outcome          = r_o_outcome;
    assign o_result_key       = r_o_key;
    assign o_result_pos_votes = r_o_pos;
    assign o_result_neg_votes = r_o_neg;
    assign o_result_flag      = r_o_flag;
    assign o_light_value      = r_o_light;

endmodule

### hdl/es_ctrl.sv
// controller state machine sequencing clear, update and read transactions
module es_ctrl import es_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DISP    = 4'd2;
    localparam logic [3:0] S_H_HASH  = 4'd3;
    localparam logic [3:0] S_MUL     = 4'd4;
    localparam logic [3:0] S_DEC     = 4'd5;
    localparam logic [3:0] S_L_START = 4'd6;
    localparam logic [3:0] S_L_HASH  = 4'd7;
    localparam logic [3:0] S_L_WR    = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.action)
                    ACT_UPDATE: begin
                        o_cmd.hash_start = 1'b1;
                        o_cmd.hash_heavy = 1'b1;
                        n_state          = S_H_HASH;
                    end
                    ACT_RD_HEAVY: begin
                        o_cmd.heavy_rd = 1'b1;
                        n_state        = S_OUT;
                    end
                    ACT_RD_LIGHT: begin
                        o_cmd.light_rd = 1'b1;
                        n_state        = S_OUT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_H_HASH: begin
                if (i_sts.hash_done) begin
                    o_cmd.heavy_rd     = 1'b1;
                    o_cmd.rd_from_hash = 1'b1;
                    n_state            = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.need_light ? S_L_START : S_OUT;
            end
            S_L_START: begin
                o_cmd.hash_start = 1'b1;
                n_state          = S_L_HASH;
            end
            S_L_HASH: begin
                if (i_sts.hash_done) begin
                    o_cmd.light_rd = 1'b1;
                    o_cmd.rd_loop  = 1'b1;
                    n_state        = S_L_WR;
                end
            end
            S_L_WR: begin
                o_cmd.light_wr = 1'b1;
                if (i_sts.last_row) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.row_inc = 1'b1;
                    n_state       = S_L_START;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### hdl/elastic_sketch_update_top.sv
// elastic sketch update: a read needs no hash; an insert or hit hashes the key once,
// and a voted-against or evicted update also hashes the key once per light row
// each key hash runs two finalizer multiplies as three 32x32 partial products each,
// then a reciprocal modulo; one transaction at a time
// a finished result waits in the output register while the next transaction is taken
// synchronous active-low reset, then a clearing pass over the max(BUCKET_COUNT,
// LIGHT_ROWS * LIGHT_COLS) entries of both memories before the first transaction
`include "elastic_sketch_update_top_defines.svh"
module elastic_sketch_update_top import es_pkg::*; #(
    parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF,
    parameter int unsigned LIGHT_ROWS   = LIGHT_ROWS_DEF,
    parameter int unsigned LIGHT_COLS   = LIGHT_COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transaction
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_flow_key,
    input  logic [13:0] i_read_index,
    // vote ratio register write
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    // result transaction
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_outcome,
    output logic [63:0] o_result_key,
    output logic [31:0] o_result_pos_votes,
    output logic [31:0] o_result_neg_votes,
    output logic        o_result_flag,
    output logic [31:0] o_light_value
);

    // command and status between controller and datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // controller: clear sweep, dispatch by action, heavy vote, light row loop
    es_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: bucket memory, count-min memory, hash unit, output register
    es_dp #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .LIGHT_ROWS   (LIGHT_ROWS),
        .LIGHT_COLS   (LIGHT_COLS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_action           (i_action),
        .i_flow_key         (i_flow_key),
        .i_read_index       (i_read_index),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_outcome          (o_outcome),
        .o_result_key       (o_result_key),
        .o_result_pos_votes (o_result_pos_votes),
        .o_result_neg_votes (o_result_neg_votes),
        .o_result_flag      (o_result_flag),
        .o_light_value      (o_light_value)
    );

    // no transaction is taken while the clearing pass runs
    `ES_ASSERT_ON(a_no_accept_in_clear, i_clk, i_rst_n, w_cmd.clr_step |-> !o_in_ready)
    // a pending result is never overwritten
    `ES_ASSERT_ON(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.out_load |-> w_sts.out_free)
    // clear sweep and bucket update never share the write port
    `ES_ASSERT_ON(a_heavy_port_excl, i_clk, i_rst_n, !(w_cmd.clr_step && w_cmd.decide))
    // after reset the block stays busy while it clears
    `ES_ASSERT_ALWAYS(a_busy_after_reset, i_clk, !i_rst_n |=> !o_in_ready)

endmodule
